[hdl/size_class_slab_allocator_assert.svh]
// Assertion macros for the slab allocator.
// Depends on nothing; included by the top level.
`ifndef SIZE_CLASS_SLAB_ALLOCATOR_ASSERT_SVH
`define SIZE_CLASS_SLAB_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define SCSA_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("assertion failed");
`define SCSA_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define SCSA_ASSERT_IMP(label, clk, rst_n, a, b)
`define SCSA_ASSERT_NXT(label, clk, rst_n, a, b)
`endif
`endif

[hdl/scsa_pkg.sv]
// Package for the slab allocator: defaults, field widths, codes, types.
// No dependencies.
`timescale 1ns / 1ps
package scsa_pkg;
    localparam int NUM_CLASSES_DEF    = 4;
    localparam int MAX_SLOTS_DEF      = 256;
    localparam int MAX_SLAB_BYTES_DEF = 4096;
    localparam int SIZE_REGS          = 4;
    localparam int SIZE_W             = 13;
    localparam int ADDR_W             = 16;
    localparam int GRANT_W            = 14;
    localparam int CCOUNT_W           = 3;
    localparam int WORD_W             = 64;

    localparam logic [2:0] REG_SLAB_BYTES  = 3'd0;
    localparam logic [2:0] REG_CLASS_COUNT = 3'd1;
    localparam logic [2:0] REG_SIZE_A      = 3'd2;
    localparam logic [2:0] REG_SIZE_B      = 3'd3;
    localparam logic [2:0] REG_SIZE_C      = 3'd4;
    localparam logic [2:0] REG_SIZE_D      = 3'd5;

    typedef enum logic [1:0] {
        STAT_OK, STAT_NO_SIZE, STAT_FULL, STAT_BAD_ADDR
    } status_t;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_A_CNT, ST_A_CNTW, ST_A_RD, ST_A_CHK, ST_A_MUL,
        ST_F_CHK, ST_F_D1, ST_F_D2, ST_F_D3, ST_F_RD, ST_F_WR, ST_DONE
    } state_t;

    typedef struct packed {
        logic              start;
        logic [ADDR_W-1:0] dividend;
        logic [SIZE_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [ADDR_W-1:0] quotient;
        logic [SIZE_W-1:0] remainder;
    } div_rsp_t;
endpackage

[hdl/scsa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module scsa_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[hdl/scsa_div.sv]
// Restoring divider, one quotient bit per cycle; start is ignored while busy.
// Depends on scsa_pkg. Divisor must be nonzero.
`timescale 1ns / 1ps
module scsa_div
    import scsa_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);
    logic [ADDR_W-1:0] quo_reg, quo_next;
    logic [SIZE_W-1:0] rem_reg, rem_next;
    logic [SIZE_W-1:0] dvs_reg;
    logic [4:0]        cnt_reg;
    logic              busy_reg, done_reg;
    logic [SIZE_W:0]   sh;
    logic              qbit;

    always_comb begin
        sh   = {rem_reg, quo_reg[ADDR_W-1]};
        qbit = (sh >= {1'b0, dvs_reg});
        rem_next = qbit ? SIZE_W'(sh - {1'b0, dvs_reg}) : SIZE_W'(sh);
        quo_next = {quo_reg[ADDR_W-2:0], qbit};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (busy_reg) begin
                quo_reg <= quo_next;
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(ADDR_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end else if (req.start) begin
                quo_reg  <= req.dividend;
                rem_reg  <= '0;
                dvs_reg  <= req.divisor;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;
endmodule

[hdl/size_class_slab_allocator.sv]
// Slab allocator: one bitmap slab per size class, bitmap in a 64-bit word RAM.
// Allocate: class match, slot count division, then a read-and-check scan of each word;
// it ends early with status FULL if no slot is free, NO_SIZE if no class size matches.
// Free: three divisions on the shared divider plus read/write.
// One item at a time; next beat in the cycle after the result loads (waits if m_ full).
// Reset clears one bitmap word per cycle before any beat.
`timescale 1ns / 1ps
`include "size_class_slab_allocator_assert.svh"
module size_class_slab_allocator
    import scsa_pkg::*;
#(
    parameter int NUM_CLASSES    = NUM_CLASSES_DEF,
    parameter int MAX_SLOTS      = MAX_SLOTS_DEF,
    parameter int MAX_SLAB_BYTES = MAX_SLAB_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [12:0] request_size, [28:13] free_address
    input  logic [0:0]  s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [13:0] granted_address
    output logic [1:0]  m_tuser,   // [1:0] status
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [12:0] cfg_wdata
);
    localparam int MAP_BITS  = NUM_CLASSES * MAX_SLOTS;
    localparam int MAP_WORDS = (MAP_BITS + WORD_W - 1) / WORD_W;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int IDXW      = (MAP_BITS > 1) ? $clog2(MAP_BITS) : 1;
    localparam int SW        = $clog2(MAX_SLOTS + 1);
    localparam int CLS_LIM   = (NUM_CLASSES < SIZE_REGS) ? NUM_CLASSES : SIZE_REGS;

    state_t state_reg, state_next;

    logic [SIZE_W-1:0]   slab_reg;
    logic [CCOUNT_W-1:0] ccount_reg;
    logic [SIZE_W-1:0]   osize_reg [SIZE_REGS];

    logic [SIZE_W-1:0]   req_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [1:0]          cls_reg;
    logic [SW-1:0]       n_reg;
    logic [ADDR_W-1:0]   slot_reg;
    logic [IDXW-1:0]     base_reg;
    logic [AW-1:0]       word_reg;
    logic [5:0]          bit_reg;
    logic [AW-1:0]       clr_reg;
    status_t             status_reg;
    logic [GRANT_W-1:0]  grant_reg;

    logic                m_valid_reg;
    logic [GRANT_W-1:0]  m_grant_reg;
    status_t             m_status_reg;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [WORD_W-1:0]   ram_wdata, ram_rdata;
    div_req_t            div_req;
    div_rsp_t            div_rsp;

    logic [SIZE_W-1:0]   slab_eff;
    logic [CCOUNT_W-1:0] ncls;
    logic [1:0]          fcls;
    logic                ffound;
    logic [SW-1:0]       n_cap;
    logic                hit;
    logic [5:0]          hit_j;
    logic                range_end;
    logic [ADDR_W-1:0]   free_limit;
    logic [SIZE_W-1:0]   d1_size;
    logic                div_wait;
    int                  lo, hi;
    int                  base_int, fidx;

    scsa_ram #(.WIDTH(WORD_W), .DEPTH(MAP_WORDS), .ADDR_W(AW)) u_ram (
        .aclk (aclk), .we (ram_we), .waddr (ram_waddr), .wdata (ram_wdata),
        .raddr (ram_raddr), .rdata (ram_rdata)
    );

    scsa_div u_div (.aclk (aclk), .aresetn (aresetn), .req (div_req), .rsp (div_rsp));

    // effective configuration and shared datapath values
    always_comb begin
        slab_eff = ({4'b0, slab_reg} > 17'(MAX_SLAB_BYTES)) ? SIZE_W'(MAX_SLAB_BYTES)
                                                            : slab_reg;
        ncls = (int'(ccount_reg) > CLS_LIM) ? CCOUNT_W'(CLS_LIM) : ccount_reg;
        fcls   = '0;
        ffound = 1'b0;
        for (int k = 0; k < SIZE_REGS; k++) begin
            if (k < int'(ncls) && req_reg != '0 && osize_reg[k] == req_reg) begin
                fcls   = 2'(k);
                ffound = 1'b1;
            end
        end
        n_cap = (div_rsp.quotient > 16'(MAX_SLOTS)) ? SW'(MAX_SLOTS)
                                                    : SW'(div_rsp.quotient);
        free_limit = 16'(ncls) * 16'(slab_eff);
        d1_size    = osize_reg[div_rsp.quotient[1:0]];
        base_int   = int'(fcls) * MAX_SLOTS;
        fidx       = int'(cls_reg) * MAX_SLOTS + int'(slot_reg);
        // slot window of this class relative to the current word
        lo = int'(base_reg) - int'(word_reg) * WORD_W;
        hi = lo + int'(n_reg);
        hit   = 1'b0;
        hit_j = '0;
        for (int j = WORD_W - 1; j >= 0; j--) begin
            if (j >= lo && j < hi && !ram_rdata[j]) begin
                hit   = 1'b1;
                hit_j = 6'(j);
            end
        end
        range_end = (hi <= WORD_W);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (clr_reg == AW'(MAP_WORDS - 1)) state_next = ST_IDLE;
            ST_IDLE:   if (s_tvalid) state_next = s_tuser[0] ? ST_F_CHK : ST_A_CNT;
            ST_A_CNT:  state_next = ffound ? ST_A_CNTW : ST_DONE;
            ST_A_CNTW: if (div_rsp.done) state_next = (n_cap == '0) ? ST_DONE : ST_A_RD;
            ST_A_RD:   state_next = ST_A_CHK;
            ST_A_CHK: begin
                if (hit) state_next = ST_A_MUL;
                else if (range_end) state_next = ST_DONE;
                else state_next = ST_A_RD;
            end
            ST_A_MUL:  state_next = ST_DONE;
            ST_F_CHK: begin
                if (slab_eff == '0 || addr_reg >= free_limit) state_next = ST_DONE;
                else state_next = ST_F_D1;
            end
            ST_F_D1:   if (div_rsp.done) state_next = (d1_size == '0) ? ST_DONE : ST_F_D2;
            ST_F_D2: begin
                if (div_rsp.done) state_next = (div_rsp.remainder != '0) ? ST_DONE : ST_F_D3;
            end
            ST_F_D3: begin
                if (div_rsp.done) state_next = (slot_reg >= 16'(n_cap)) ? ST_DONE : ST_F_RD;
            end
            ST_F_RD:   state_next = ST_F_WR;
            ST_F_WR:   state_next = ST_DONE;
            ST_DONE:   if (!m_valid_reg || m_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_tready         = (state_reg == ST_IDLE);
        ram_we           = 1'b0;
        ram_waddr        = word_reg;
        ram_wdata        = ram_rdata;
        ram_raddr        = word_reg;
        div_req.start    = 1'b0;
        div_req.dividend = {3'b0, slab_eff};
        div_req.divisor  = osize_reg[cls_reg];
        unique case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
            end
            ST_A_CNT: begin
                div_req.start   = ffound;
                div_req.divisor = osize_reg[fcls];
            end
            ST_A_CHK: begin
                ram_we    = hit;
                ram_wdata = ram_rdata | (WORD_W'(1) << hit_j);
            end
            ST_F_CHK: begin
                div_req.start    = !(slab_eff == '0 || addr_reg >= free_limit);
                div_req.dividend = addr_reg;
                div_req.divisor  = slab_eff;
            end
            ST_F_D1: begin
                div_req.start    = div_rsp.done && d1_size != '0;
                div_req.dividend = {3'b0, div_rsp.remainder};
                div_req.divisor  = d1_size;
            end
            ST_F_D2: begin
                div_req.start = div_rsp.done && div_rsp.remainder == '0;
            end
            ST_F_WR: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata & ~(WORD_W'(1) << bit_reg);
            end
            default: begin
            end
        endcase
    end

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slab_reg     <= SIZE_W'(256);
            ccount_reg   <= CCOUNT_W'(4);
            osize_reg[0] <= SIZE_W'(8);
            osize_reg[1] <= SIZE_W'(16);
            osize_reg[2] <= SIZE_W'(32);
            osize_reg[3] <= SIZE_W'(64);
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SLAB_BYTES:  slab_reg     <= cfg_wdata;
                REG_CLASS_COUNT: ccount_reg   <= cfg_wdata[CCOUNT_W-1:0];
                REG_SIZE_A:      osize_reg[0] <= cfg_wdata;
                REG_SIZE_B:      osize_reg[1] <= cfg_wdata;
                REG_SIZE_C:      osize_reg[2] <= cfg_wdata;
                REG_SIZE_D:      osize_reg[3] <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) clr_reg <= clr_reg + AW'(1);
            if (state_reg == ST_DONE && (!m_valid_reg || m_tready)) m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_tready) m_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                req_reg    <= s_tdata[SIZE_W-1:0];
                addr_reg   <= s_tdata[SIZE_W+ADDR_W-1:SIZE_W];
                grant_reg  <= '0;
                status_reg <= s_tuser[0] ? STAT_BAD_ADDR : STAT_NO_SIZE;
            end
            ST_A_CNT: begin
                cls_reg  <= fcls;
                base_reg <= IDXW'(base_int);
                word_reg <= AW'(base_int >> 6);
                if (ffound) status_reg <= STAT_FULL;
            end
            ST_A_CNTW: n_reg <= n_cap;
            ST_A_CHK: begin
                if (hit) slot_reg <= 16'(int'(word_reg) * WORD_W + int'(hit_j)
                                         - int'(base_reg));
                else word_reg <= word_reg + AW'(1);
            end
            ST_A_MUL: begin
                grant_reg  <= GRANT_W'(cls_reg) * GRANT_W'(slab_eff)
                            + slot_reg[GRANT_W-1:0] * GRANT_W'(req_reg);
                status_reg <= STAT_OK;
            end
            ST_F_D1: if (div_rsp.done) cls_reg <= div_rsp.quotient[1:0];
            ST_F_D2: if (div_rsp.done) slot_reg <= div_rsp.quotient;
            ST_F_D3: begin
                word_reg <= AW'(fidx >> 6);
                bit_reg  <= 6'(fidx);
            end
            ST_F_WR: status_reg <= STAT_OK;
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_grant_reg  <= grant_reg;
                    m_status_reg <= status_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_grant_reg};
    assign m_tuser  = m_status_reg;

    // states that wait on the divider
    assign div_wait = (state_reg == ST_A_CNTW || state_reg == ST_F_D1 ||
                       state_reg == ST_F_D2 || state_reg == ST_F_D3);

    `SCSA_ASSERT_IMP(a_div_done_waited, aclk, aresetn, div_rsp.done, div_wait)
    `SCSA_ASSERT_IMP(a_alloc_sets_one, aclk, aresetn, ram_we && state_reg == ST_A_CHK, $countones(ram_wdata ^ ram_rdata) == 1)
    `SCSA_ASSERT_IMP(a_free_sets_none, aclk, aresetn, state_reg == ST_F_WR, (ram_wdata & ~ram_rdata) == '0)
    `SCSA_ASSERT_NXT(a_alloc_ok_out, aclk, aresetn, state_reg == ST_A_MUL, status_reg == STAT_OK)
endmodule
